/* sv/assert_macros.svh */
// Assertion helpers for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked implication checked only outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Clocked implication, consequent checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Condition that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

`endif

/* sv/slp_pkg.sv */
// ----------------------------------------------------------------------------
// slp_pkg
// Types and constants of the string literal parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package slp_pkg;

    localparam int MAX_LEN = 1024;
    localparam int CNT_W   = $clog2(MAX_LEN + 1);
    localparam int LEN_W   = 11;

    localparam logic [1:0] KIND_DATA = 2'd0;
    localparam logic [1:0] KIND_DONE = 2'd1;
    localparam logic [1:0] KIND_EOF  = 2'd2;
    localparam logic [1:0] KIND_OVF  = 2'd3;

    localparam logic [1:0] PH_NORMAL = 2'd0;
    localparam logic [1:0] PH_ESC    = 2'd1;
    localparam logic [1:0] PH_OCT1   = 2'd2;
    localparam logic [1:0] PH_OCT2   = 2'd3;

    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_7      = 8'h37;

    localparam logic [7:0] BYTE_LF = 8'h0A;
    localparam logic [7:0] BYTE_CR = 8'h0D;
    localparam logic [7:0] BYTE_HT = 8'h09;
    localparam logic [7:0] BYTE_BS = 8'h08;
    localparam logic [7:0] BYTE_FF = 8'h0C;

    typedef struct packed {
        logic [CNT_W-1:0] nest_depth;
        logic [CNT_W-1:0] byte_count;
        logic [1:0]       phase;
        logic [7:0]       octal_accum;
    } slp_state_t;

    typedef struct packed {
        logic             valid;
        logic [1:0]       kind;
        logic [7:0]       data_byte;
        logic [LEN_W-1:0] total_length;
        logic             final_res;
    } slp_res_t;

endpackage

/* sv/string_literal_parser_unit.sv */
// ----------------------------------------------------------------------------
// string_literal_parser_unit
// Decodes the body of a parenthesized string literal into bytes.
// ----------------------------------------------------------------------------
// Feed the characters after the opening parenthesis, one word each, tlast set
// on the word that marks end of input. One word is accepted every cycle unless
// a result waits unaccepted at the output; each passes an input register and
// then one decode step into the output register. The parser state (nesting
// depth, byte count, escape phase, octal value) loops through that decode step
// once per word taken, which sets the rate. Words that cause no result
// (backslash, first octal digits, line continuation) simply produce nothing.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module string_literal_parser_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,   // escape_enable
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,       // [7:0] char_in
    input  logic        s_tlast,       // at_end
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,       // [7:0] data_byte, [18:8] total_length
    output logic [1:0]  m_tuser,       // [1:0] kind
    output logic        m_tlast        // final_res
);
    import slp_pkg::*;

    logic       esc_en_reg;
    logic       in_valid_reg;
    logic [7:0] in_char_reg;
    logic       in_end_reg;
    slp_state_t state_reg;
    slp_state_t state_next;
    slp_res_t   res;
    logic       out_valid_reg;
    slp_res_t   out_reg;
    logic       advance;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    slp_step u_step (
        .state         (state_reg),
        .char_in       (in_char_reg),
        .at_end        (in_end_reg),
        .escape_enable (esc_en_reg),
        .state_next    (state_next),
        .res           (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            esc_en_reg    <= 1'b1;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                esc_en_reg <= cfg_wr_data;
            end
            if (s_tvalid && s_tready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                state_reg     <= state_next;
                out_valid_reg <= res.valid;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_char_reg <= s_tdata;
            in_end_reg  <= s_tlast;
        end
        if (advance)
        begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b00000, out_reg.total_length, out_reg.data_byte};
    assign m_tuser  = out_reg.kind;
    assign m_tlast  = out_reg.final_res;

    `ASSERT_IMPL(a_final_kind, clk, rst_n, m_tvalid, m_tlast == (m_tuser != KIND_DATA),
        "final flag disagrees with result kind")
    `ASSERT_ALWAYS(a_count_bound, clk, rst_n, state_reg.byte_count <= CNT_W'(MAX_LEN),
        "byte count beyond maximum length")
    `ASSERT_ALWAYS(a_depth_bound, clk, rst_n, state_reg.nest_depth <= state_reg.byte_count,
        "nesting depth exceeds byte count")
    `ASSERT_NEXT(a_final_clears, clk, rst_n, advance && res.final_res,
        state_reg == slp_state_t'('0), "state not cleared after final result")

endmodule

/* sv/slp_step.sv */
// ----------------------------------------------------------------------------
// slp_step
// Per-character decode: next parser state and the result word, if any.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module slp_step (
    input  slp_pkg::slp_state_t state,
    input  logic [7:0]          char_in,
    input  logic                at_end,
    input  logic                escape_enable,
    output slp_pkg::slp_state_t state_next,
    output slp_pkg::slp_res_t   res
);
    import slp_pkg::*;

    logic       emit;
    logic [7:0] emit_byte;
    logic       fin;
    logic [1:0] fin_kind;
    logic [7:0] oct_sum;
    slp_state_t st;

    assign oct_sum = {state.octal_accum[4:0], 3'b000} + char_in - CH_0;

    always_comb
    begin
        st        = state;
        emit      = 1'b0;
        emit_byte = char_in;
        fin       = 1'b0;
        fin_kind  = KIND_DONE;
        case (state.phase)
            PH_NORMAL:
            begin
                if (state.byte_count >= CNT_W'(MAX_LEN))
                begin
                    fin      = 1'b1;
                    fin_kind = KIND_OVF;
                end
                else if (at_end)
                begin
                    fin      = 1'b1;
                    fin_kind = KIND_EOF;
                end
                else if (char_in == CH_LPAREN)
                begin
                    st.nest_depth = state.nest_depth + 1'b1;
                    emit          = 1'b1;
                end
                else if (char_in == CH_RPAREN)
                begin
                    if (state.nest_depth == '0)
                    begin
                        fin      = 1'b1;
                        fin_kind = KIND_DONE;
                    end
                    else
                    begin
                        st.nest_depth = state.nest_depth - 1'b1;
                        emit          = 1'b1;
                    end
                end
                else if (char_in == CH_BSLASH && escape_enable)
                begin
                    st.phase = PH_ESC;
                end
                else
                begin
                    emit = 1'b1;
                end
            end
            PH_ESC:
            begin
                if (at_end)
                begin
                    fin      = 1'b1;
                    fin_kind = KIND_EOF;
                end
                else
                begin
                    st.phase = PH_NORMAL;
                    case (char_in)
                        CH_NL: ;   // line continuation, no byte
                        CH_N:
                        begin
                            emit      = 1'b1;
                            emit_byte = BYTE_LF;
                        end
                        CH_R:
                        begin
                            emit      = 1'b1;
                            emit_byte = BYTE_CR;
                        end
                        CH_T:
                        begin
                            emit      = 1'b1;
                            emit_byte = BYTE_HT;
                        end
                        CH_B:
                        begin
                            emit      = 1'b1;
                            emit_byte = BYTE_BS;
                        end
                        CH_F:
                        begin
                            emit      = 1'b1;
                            emit_byte = BYTE_FF;
                        end
                        default:
                        begin
                            if (char_in inside {[CH_0:CH_7]})
                            begin
                                st.octal_accum = {5'b00000, char_in[2:0]};
                                st.phase       = PH_OCT1;
                            end
                            else
                            begin
                                emit = 1'b1;
                            end
                        end
                    endcase
                end
            end
            PH_OCT1:
            begin
                if (at_end)
                begin
                    fin      = 1'b1;
                    fin_kind = KIND_EOF;
                end
                else
                begin
                    st.octal_accum = oct_sum;
                    st.phase       = PH_OCT2;
                end
            end
            default:
            begin
                if (at_end)
                begin
                    fin      = 1'b1;
                    fin_kind = KIND_EOF;
                end
                else
                begin
                    st.octal_accum = oct_sum;
                    st.phase       = PH_NORMAL;
                    emit           = 1'b1;
                    emit_byte      = oct_sum;
                end
            end
        endcase

        if (emit)
        begin
            st.byte_count = state.byte_count + 1'b1;
        end

        res.valid        = emit | fin;
        res.kind         = fin ? fin_kind : KIND_DATA;
        res.data_byte    = fin ? 8'h00 : emit_byte;
        res.total_length = (fin && fin_kind == KIND_DONE) ? LEN_W'(state.byte_count) : '0;
        res.final_res    = fin;

        // any final result starts a fresh string
        state_next = fin ? slp_state_t'('0) : st;
    end

endmodule
